// ----- hw/rtl/catan_pkg.sv -----
package catan_pkg;

    localparam int ITERATIONS = 24;
    localparam int TABLE_SIZE = 30;

    // The table holds 30 entries, so at most 30 micro-rotations are built.
    localparam int NUM_STAGES = (ITERATIONS < TABLE_SIZE) ? ITERATIONS : TABLE_SIZE;
    localparam int SHIFT_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    localparam int VALUE_W = 32;
    localparam int ANGLE_W = 32;
    localparam int WORD_W  = 48;

    // Fraction bits of the Q17.30 working words and of the Q16.16 input.
    localparam int WORD_FRAC  = 30;
    localparam int VALUE_FRAC = 16;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  re;
        logic signed [WORD_W-1:0]  im;
        logic signed [ANGLE_W-1:0] ang;
    } catan_vec_t;

    // atan(2^-k) in Q2.29, rounded to nearest.
    localparam angle_t ATAN_TABLE [TABLE_SIZE] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579, 32'sd33510843,
        32'sd16771758,  32'sd8387925,   32'sd4194219,   32'sd2097141,  32'sd1048575,
        32'sd524288,    32'sd262144,    32'sd131072,    32'sd65536,    32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,     32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64,       32'sd32,
        32'sd16,        32'sd8,         32'sd4,         32'sd2,        32'sd1
    };

    function automatic angle_t atan_entry(input logic [SHIFT_W-1:0] idx);
        atan_entry = ATAN_TABLE[idx];
    endfunction

endpackage

// ----- hw/rtl/catan_stage.sv -----
module catan_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [catan_pkg::SHIFT_W-1:0]     shift_amt,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  catan_pkg::catan_vec_t             up_data,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output catan_pkg::catan_vec_t             dn_data
);

    logic                              valid_reg;
    logic                              valid_next;
    catan_pkg::catan_vec_t             data_reg;
    catan_pkg::catan_vec_t             data_next;
    logic signed [catan_pkg::WORD_W-1:0]  re_shr;
    logic signed [catan_pkg::WORD_W-1:0]  im_shr;
    catan_pkg::angle_t                 atan_k;

    // The stage takes a new item whenever it is empty or its item leaves now.
    assign up_ready = !valid_reg || dn_ready;

    assign re_shr = up_data.re >>> shift_amt;
    assign im_shr = up_data.im >>> shift_amt;
    assign atan_k = catan_pkg::atan_entry(shift_amt);

    always_comb
    begin
        // A zero imaginary part counts as non-negative.
        if (up_data.im[catan_pkg::WORD_W-1])
        begin
            data_next.re  = up_data.re - im_shr;
            data_next.im  = up_data.im + re_shr;
            data_next.ang = up_data.ang - atan_k;
        end
        else
        begin
            data_next.re  = up_data.re + im_shr;
            data_next.im  = up_data.im - re_shr;
            data_next.ang = up_data.ang + atan_k;
        end
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- hw/rtl/cordic_arctangent.sv -----
// Pipeline: an accepted item passes through one register stage for each micro-rotation,
// the last stage being the output register, where its angle waits until out_ready.
// Throughput: one item per cycle; a stage holds its item while the next cannot take it.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits; the
// data registers keep whatever they hold until an item is loaded.
module cordic_arctangent (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [catan_pkg::VALUE_W-1:0]    value,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [catan_pkg::ANGLE_W-1:0]    angle
);

    localparam int N = catan_pkg::NUM_STAGES;

    logic [N:0]             stg_valid;
    logic [N:0]             stg_ready;
    catan_pkg::catan_vec_t  stg_data [N+1];

    // The vector starts at (1.0, value) in Q17.30.
    assign stg_valid[0]    = in_valid;
    assign in_ready        = stg_ready[0];
    assign stg_data[0].re  = catan_pkg::WORD_W'(1) <<< catan_pkg::WORD_FRAC;
    assign stg_data[0].im  = catan_pkg::WORD_W'(value) <<<
                             (catan_pkg::WORD_FRAC - catan_pkg::VALUE_FRAC);
    assign stg_data[0].ang = '0;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            catan_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_amt (catan_pkg::SHIFT_W'(i)),
                .up_valid  (stg_valid[i]),
                .up_ready  (stg_ready[i]),
                .up_data   (stg_data[i]),
                .dn_valid  (stg_valid[i+1]),
                .dn_ready  (stg_ready[i+1]),
                .dn_data   (stg_data[i+1])
            );
        end
    endgenerate

    assign stg_ready[N] = out_ready;
    assign out_valid    = stg_valid[N];
    assign angle        = stg_data[N].ang;

    // Input backpressure only occurs when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&stg_valid[N:1]))
        else $error("input stalled while a stage is empty");

    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> stg_valid[1])
        else $error("accepted item did not enter the first stage");

    // The sum of all table angles stays below 2^30, so the result is bounded.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((angle < 32'sh4000_0000) && (angle > -32'sh4000_0000)))
        else $error("angle outside the reachable range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid[1] && !stg_ready[1]) |=> stg_valid[1])
        else $error("first stage dropped a stalled item");

endmodule

// ----- tb/cordic_arctangent_tb.sv -----
`timescale 1ns / 1ps

module cordic_arctangent_tb;

    localparam int VALUE_W    = catan_pkg::VALUE_W;
    localparam int ANGLE_W    = catan_pkg::ANGLE_W;

    // The table has 30 entries, so no more than 30 rotations take place.
    localparam int ROTATIONS  = (catan_pkg::ITERATIONS < 30) ? catan_pkg::ITERATIONS : 30;
    localparam int WIDE_W     = 48;
    localparam int IDLE_PCT   = 22;
    localparam int HOLD_LEN   = 150;
    localparam int HOLD_AT    = 300;
    localparam int STALL_MAX  = 1000;
    localparam int FLUSH_WAIT = 40;

    // atan(2^-k) in Q2.29, rounded to nearest.
    localparam logic signed [ANGLE_W-1:0] ATAN_Q29 [30] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579, 32'sd33510843,
        32'sd16771758,  32'sd8387925,   32'sd4194219,   32'sd2097141,  32'sd1048575,
        32'sd524288,    32'sd262144,    32'sd131072,    32'sd65536,    32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,     32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64,       32'sd32,
        32'sd16,        32'sd8,         32'sd4,         32'sd2,        32'sd1
    };

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed [VALUE_W-1:0]   value = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [ANGLE_W-1:0]   angle;

    logic signed [VALUE_W-1:0]   pending_values [$];
    logic signed [VALUE_W-1:0]   sent_values [$];
    logic signed [ANGLE_W-1:0]   expected_angles [$];

    int queued_total   = 0;
    int accepted_total = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit steady;

    cordic_arctangent u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .angle     (angle)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Vectoring from (1, tan) toward the real axis; the accumulated angle is atan(tan).
    function automatic logic signed [ANGLE_W-1:0] arctan_q29(
        input logic signed [VALUE_W-1:0] tangent);
        logic signed [WIDE_W-1:0]  re;
        logic signed [WIDE_W-1:0]  im;
        logic signed [WIDE_W-1:0]  re_prev;
        logic signed [ANGLE_W-1:0] acc;
        re  = 48'sd1 <<< 30;
        im  = tangent;
        im  = im <<< 14;
        acc = '0;
        for (int k = 0; k < ROTATIONS; k++)
        begin
            re_prev = re;
            if (im < 0)
            begin
                re  = re - (im >>> k);
                im  = im + (re_prev >>> k);
                acc = acc - ATAN_Q29[k];
            end
            else
            begin
                re  = re + (im >>> k);
                im  = im - (re_prev >>> k);
                acc = acc + ATAN_Q29[k];
            end
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [VALUE_W-1:0] arg,
                                   input logic signed [ANGLE_W-1:0] got,
                                   input logic signed [ANGLE_W-1:0] want);
        $display("MISMATCH %s: value=%0d angle=%0d expected=%0d", what, arg, got, want);
        mismatch_count++;
    endtask

    task automatic queue_value(input logic signed [VALUE_W-1:0] v);
        pending_values.push_back(v);
        queued_total++;
    endtask

    // Both sides stop idling for a while in the middle of the random part.
    assign steady = (accepted_total >= 450) && (accepted_total < 600);

    // Sender: offers the next pending item, holding it until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_angles.push_back(arctan_q29(value));
                sent_values.push_back(value);
                accepted_total <= accepted_total + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_values.size() > 0
                    && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    value    <= pending_values.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness, including one long hold-off that backs up the pipeline.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_total >= HOLD_AT)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_angles.size() == 0)
                report_mismatch("unexpected item", 'x, angle, 'x);
            else if (angle !== expected_angles[0])
                report_mismatch("angle", sent_values[0], angle, expected_angles[0]);
            if (expected_angles.size() > 0)
            begin
                void'(expected_angles.pop_front());
                void'(sent_values.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX)
            begin
                $display("cordic_arctangent test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int draw;
        logic signed [VALUE_W-1:0] v;

        // Extremes, exact zero, and tan = 1 (zero after the first step).
        queue_value(32'sd0);
        queue_value(32'sd1);
        queue_value(-32'sd1);
        queue_value(32'sd65536);
        queue_value(-32'sd65536);
        queue_value(32'sh7FFF_FFFF);
        queue_value(32'sh8000_0000);
        queue_value(32'sd32768);
        queue_value(-32'sd32768);
        queue_value(32'sd655360);
        queue_value(32'sd2);
        queue_value(32'sh0001_0001);
        queue_value(32'shFFFF_0000);
        queue_value(32'sd113512);
        queue_value(32'sd37837);
        queue_value(32'sh5555_5555);
        queue_value(32'shAAAA_AAAA);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The sender pauses here until every angle so far has come back.
        while (accepted_total < queued_total || expected_angles.size() > 0)
            @(posedge clk);

        for (int i = 0; i < 850; i++)
        begin
            draw = $urandom_range(99);
            if (draw < 40)
                v = $urandom;
            else if (draw < 80)
                v = $signed($urandom_range(1048576)) - 524288;
            else
                v = $signed($urandom_range(512)) - 256;
            queue_value(v);
        end

        while (accepted_total < queued_total || expected_angles.size() > 0)
            @(posedge clk);
        repeat (FLUSH_WAIT) @(posedge clk);

        if (mismatch_count == 0 && expected_angles.size() == 0)
            $display("cordic_arctangent test passed");
        else
            $display("cordic_arctangent test failed");
        $finish;
    end

endmodule
